/* rtl/feedback_echo_saturating_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the echo block.
// Assertions compile unless SYNTH is defined; then the macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef FEEDBACK_ECHO_SATURATING_MACROS_SVH
`define FEEDBACK_ECHO_SATURATING_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted
`define FES_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted
`define FES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FES_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define FES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/fes_pkg.sv */
// ----------------------------------------------------------------------------
// fes_pkg
// Shared types and constants for the saturating feedback echo.
// ----------------------------------------------------------------------------
package fes_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int DELAY_W   = 17;
    localparam int GAIN_W    = 16;
    localparam int SEEN_W    = 17;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 1'b1;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 17'd44100;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd16384;
    localparam logic [SEEN_W-1:0]  SEEN_MAX    = 17'h1FFFF;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       stream_start;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       clipped;
    } t_out;

endpackage

/* rtl/fes_scale_sat.sv */
// ----------------------------------------------------------------------------
// fes_scale_sat
// Scales the delayed sample by the Q1.15 gain (truncated toward zero), adds
// the input sample and saturates the sum to 16 bits with a clip flag.
// ----------------------------------------------------------------------------
module fes_scale_sat (
    input  logic signed [fes_pkg::SAMPLE_W-1:0] i_x,
    input  logic signed [fes_pkg::SAMPLE_W-1:0] i_echo,
    input  logic        [fes_pkg::GAIN_W-1:0]   i_gain,
    input  logic                                i_use_echo,
    output fes_pkg::t_out                       o_res
);
    import fes_pkg::*;

    logic                           echo_neg;
    logic [SAMPLE_W-1:0]            echo_mag;
    logic [SAMPLE_W+GAIN_W-1:0]     prod;
    logic [SAMPLE_W:0]              prod_q;
    logic signed [SAMPLE_W+1:0]     term;
    logic signed [SAMPLE_W+1:0]     sum;
    logic                           ovf;

    // Magnitude of the delayed sample; the most negative value maps to 32768
    assign echo_neg = i_echo[SAMPLE_W-1];
    assign echo_mag = echo_neg ? (~i_echo + 1'b1) : i_echo;

    // Scale and drop the fraction, then restore the sign
    assign prod   = {{GAIN_W{1'b0}}, echo_mag} * {{SAMPLE_W{1'b0}}, i_gain};
    assign prod_q = prod[SAMPLE_W+GAIN_W-1:GAIN_W-1];
    assign term   = echo_neg ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});

    // Add and detect overflow from the top three sum bits
    assign sum = {{2{i_x[SAMPLE_W-1]}}, i_x} + term;
    assign ovf = !((sum[SAMPLE_W+1] == sum[SAMPLE_W]) &&
                   (sum[SAMPLE_W] == sum[SAMPLE_W-1]));

    always_comb begin
        o_res.sample_out = i_x;
        o_res.clipped    = 1'b0;
        if (i_use_echo) begin
            if (!ovf) begin
                o_res.sample_out = sum[SAMPLE_W-1:0];
            end else if (sum[SAMPLE_W+1]) begin
                o_res.sample_out = SAMPLE_MIN;
                o_res.clipped    = 1'b1;
            end else begin
                o_res.sample_out = SAMPLE_MAX;
                o_res.clipped    = 1'b1;
            end
        end
    end

endmodule

/* rtl/feedback_echo_saturating.sv */
// ----------------------------------------------------------------------------
// feedback_echo_saturating
// Feedback comb echo: y = sat16(x + trunc0(y[D samples back] * gain)).
// Pipeline: an accepted sample passes the compute stage register and then the
// output register, which drives o_out_valid and o_out_data.
// Throughput: one sample per cycle while the output is not stalled; the echo line read
// data, scale, add and write-back close the one-sample feedback loop in the compute stage.
// Reset clears pointer, sample count, pipeline valids and restores the
// register defaults; the echo line is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "feedback_echo_saturating_macros.svh"

module feedback_echo_saturating #(
    parameter int MAX_DELAY = 65536
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [fes_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fes_pkg::DELAY_W-1:0]       i_cfg_data,
    // Input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  fes_pkg::t_in                      i_in_data,
    // Output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output fes_pkg::t_out                     o_out_data
);
    import fes_pkg::*;

    localparam int AW  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int CWM = $clog2(MAX_DELAY + 1);
    localparam int CW  = (CWM > DELAY_W) ? CWM : DELAY_W;
    localparam logic [CW-1:0] MAX_D  = CW'(MAX_DELAY);
    localparam logic [AW-1:0] LAST_A = AW'(MAX_DELAY - 1);

    // Configuration
    logic [DELAY_W-1:0]          r_delay;
    logic [GAIN_W-1:0]           r_gain;

    // Stream state
    logic [AW-1:0]               r_wp, n_wp;
    logic [SEEN_W-1:0]           r_seen, n_seen;

    // Echo line
    logic [SAMPLE_W-1:0]         r_echo_line [MAX_DELAY];
    logic [SAMPLE_W-1:0]         r_mem_q;

    // Compute stage
    logic                        r_s1_vld;
    logic signed [SAMPLE_W-1:0]  r_s1_x;
    logic                        r_s1_use;
    logic [AW-1:0]               r_s1_wp;
    logic                        r_s1_fwd;
    logic [SAMPLE_W-1:0]         r_fwd_data;

    // Output register
    logic                        r_o_vld;
    t_out                        r_o_data;

    logic                        in_xfer;
    logic                        s1_adv;
    logic [SEEN_W-1:0]           seen_eff;
    logic [CW-1:0]               d_ext, d_clamp, wp_ext;
    logic                        n_use;
    logic [AW-1:0]               rd_addr;
    logic signed [SAMPLE_W-1:0]  s1_echo;
    t_out                        s1_res;

    // Handshake
    assign s1_adv      = r_s1_vld && (!r_o_vld || !i_out_stall);
    assign o_in_stall  = r_s1_vld && !s1_adv;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_o_vld;
    assign o_out_data  = r_o_data;

    // Clamp delay, decide on echo, form the read address
    always_comb begin
        seen_eff = i_in_data.stream_start ? '0 : r_seen;
        d_ext    = CW'(r_delay);
        d_clamp  = (d_ext > MAX_D) ? MAX_D : d_ext;
        wp_ext   = CW'(r_wp);
        n_use    = (d_clamp != '0) && (CW'(seen_eff) >= d_clamp);
        if (wp_ext >= d_clamp) begin
            rd_addr = AW'(wp_ext - d_clamp);
        end else begin
            rd_addr = AW'(wp_ext + MAX_D - d_clamp);
        end
        n_wp   = (r_wp == LAST_A) ? '0 : r_wp + 1'b1;
        n_seen = (seen_eff == SEEN_MAX) ? seen_eff : seen_eff + 1'b1;
    end

    // Take forwarded data when the previous sample wrote the entry being read
    assign s1_echo = r_s1_fwd ? r_fwd_data : r_mem_q;

    fes_scale_sat u_scale_sat (
        .i_x        (r_s1_x),
        .i_echo     (s1_echo),
        .i_gain     (r_gain),
        .i_use_echo (r_s1_use),
        .o_res      (s1_res)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= DELAY_RESET;
            r_gain   <= GAIN_RESET;
            r_wp     <= '0;
            r_seen   <= '0;
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DELAY: r_delay <= i_cfg_data;
                    CFG_GAIN:  r_gain  <= i_cfg_data[GAIN_W-1:0];
                    default:   r_delay <= r_delay;
                endcase
            end
            if (in_xfer) begin
                r_wp   <= n_wp;
                r_seen <= n_seen;
            end
            if (in_xfer) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_o_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // Echo line: read on input transfer, write back when a result leaves
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_mem_q <= r_echo_line[rd_addr];
        end
        if (s1_adv) begin
            r_echo_line[r_s1_wp] <= s1_res.sample_out;
        end
    end

    // Stage and output payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_x     <= i_in_data.sample_in;
            r_s1_use   <= n_use;
            r_s1_wp    <= r_wp;
            r_s1_fwd   <= s1_adv && (rd_addr == r_s1_wp);
            r_fwd_data <= s1_res.sample_out;
        end
        if (s1_adv) begin
            r_o_data <= s1_res;
        end
    end

    // Checks
    `FES_ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n, r_s1_vld && r_o_vld && i_out_stall, r_s1_vld)
    `FES_ASSERT_SAME(a_stall_needs_item, i_clk, i_rst_n, o_in_stall, r_s1_vld)
    `FES_ASSERT_SAME(a_clip_at_rail, i_clk, i_rst_n, o_out_valid && o_out_data.clipped, o_out_data.sample_out == SAMPLE_MAX || o_out_data.sample_out == SAMPLE_MIN)
    `FES_ASSERT_SAME(a_pass_through, i_clk, i_rst_n, r_s1_vld && !r_s1_use, s1_res.sample_out == r_s1_x && !s1_res.clipped)

endmodule

/* verif/echo_checker.sv */
// ----------------------------------------------------------------------------
// echo_checker
// Watches the config port and both channels of the saturating feedback echo.
// Keeps its own echo line, pointer and sample count, and predicts every output
// sample. It compares each output transfer, field by field, with the oldest
// prediction and counts mismatches.
// ----------------------------------------------------------------------------
module echo_checker #(
    parameter int MAX_DELAY = 65536
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fes_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fes_pkg::DELAY_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  fes_pkg::t_in                  i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  fes_pkg::t_out                 i_out_data,
    output int                            o_errors,
    output int                            o_pending
);
    import fes_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copies of the block's registers and state
    logic [DELAY_W-1:0]  delay_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [SAMPLE_W-1:0] echo_line [MAX_DELAY];
    int                  wr_ptr;
    int                  seen;

    t_out expected_echo_q [$];
    int   mismatches = 0;
    int   waiting = 0;

    assign o_errors  = mismatches;
    assign o_pending = waiting;

    // Compute one output sample and advance the echo state
    function automatic t_out echo_sample(input t_in item);
        t_out  res;
        int    d;
        int    x;
        int    past;
        int    mag;
        int    scaled;
        int    sum;
        int    rd;
        logic  clip;

        x    = $signed(item.sample_in);
        sum  = x;
        clip = 1'b0;
        if (item.stream_start) begin
            seen = 0;
        end
        d = int'(delay_reg);
        if (d > MAX_DELAY) begin
            d = MAX_DELAY;
        end

        // Echo only once D samples of this stream are in the line
        if (d != 0 && seen >= d) begin
            rd     = (wr_ptr + MAX_DELAY - d) % MAX_DELAY;
            past   = $signed(echo_line[rd]);
            mag    = (past < 0) ? -past : past;
            scaled = int'((longint'(mag) * longint'(gain_reg)) >> 15);
            sum    = x + ((past < 0) ? -scaled : scaled);
            if (sum > 32767) begin
                sum  = 32767;
                clip = 1'b1;
            end else if (sum < -32768) begin
                sum  = -32768;
                clip = 1'b1;
            end
        end

        res.sample_out   = sum[SAMPLE_W-1:0];
        res.clipped      = clip;
        echo_line[wr_ptr] = res.sample_out;
        wr_ptr = (wr_ptr + 1) % MAX_DELAY;
        if (seen < int'(SEEN_MAX)) begin
            seen++;
        end
        return res;
    endfunction

    // Track config, predict on input transfers, compare on output transfers
    always @(posedge i_clk) begin : watch
        t_out want;
        t_out got;

        if (!i_rst_n) begin
            delay_reg = DELAY_RESET;
            gain_reg  = GAIN_RESET;
            wr_ptr    = 0;
            seen      = 0;
            expected_echo_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_DELAY) begin
                    delay_reg = i_cfg_data;
                end else if (i_cfg_index == CFG_GAIN) begin
                    gain_reg = i_cfg_data[GAIN_W-1:0];
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_echo_q.push_back(echo_sample(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (expected_echo_q.size() == 0) begin
                    $display("%0t: unexpected output transfer: sample_out %0d clipped %0b",
                             $time, $signed(got.sample_out), got.clipped);
                    mismatches++;
                end else begin
                    want = expected_echo_q.pop_front();
                    if (got.sample_out !== want.sample_out) begin
                        $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                                 $time, $signed(want.sample_out), $signed(got.sample_out));
                        mismatches++;
                    end
                    if (got.clipped !== want.clipped) begin
                        $display("%0t: clipped mismatch: expected %0b, actual %0b",
                                 $time, want.clipped, got.clipped);
                        mismatches++;
                    end
                end
            end
        end
        waiting = expected_echo_q.size();
    end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the saturating feedback echo with directed and random sample streams
// across many delay and gain settings, with random gaps and output stalls.
// The echo checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import fes_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ECHO_DEPTH   = 65536;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1400;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_DELAY;
    logic [DELAY_W-1:0]   i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out                 o_out_data;

    int   errors;
    int   pending;
    bit   no_idle = 1'b0;
    int   idle_cycles = 0;

    feedback_echo_saturating #(
        .MAX_DELAY  (ECHO_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    echo_checker #(
        .MAX_DELAY  (ECHO_DEPTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Stop the run when nothing transfers for too long
    initial begin
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("** feedback_echo_saturating: FAILED **");
                $finish;
            end
        end
    end

    // Hold the output stall for a random number of cycles per output transfer
    initial begin : out_stall_gen
        int hold;
        @(negedge i_clk);
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 13);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
            @(negedge i_clk);
        end
    end

    function automatic t_in mk_item(input logic signed [SAMPLE_W-1:0] s, input logic first);
        t_in item;
        item.sample_in    = s;
        item.stream_start = first;
        return item;
    endfunction

    // Favor the rails, zero and small values, otherwise any 16-bit pattern
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            3:       return SAMPLE_W'($signed($urandom_range(0, 16)) - 8);
            4:       return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [DELAY_W-1:0] pick_delay();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return DELAY_W'(1);
            2:       return DELAY_W'(2);
            3, 4, 5, 6, 7, 8: return DELAY_W'($urandom_range(1, 16));
            9, 10, 11, 12:    return DELAY_W'($urandom_range(17, 300));
            13:      return DELAY_W'(ECHO_DEPTH);
            14:      return '1;
            default: return DELAY_W'($urandom_range(ECHO_DEPTH + 1, 131070));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return GAIN_W'(1);
            2:       return GAIN_W'(16384);
            3:       return GAIN_W'(32767);
            4:       return GAIN_W'(32768);
            5:       return '1;
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    // Write both registers on consecutive cycles; call only when drained
    task automatic write_config(input logic [DELAY_W-1:0] delay,
                                input logic [GAIN_W-1:0] gain);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DELAY;
        i_cfg_data  <= delay;
        @(negedge i_clk);
        i_cfg_index <= CFG_GAIN;
        i_cfg_data  <= DELAY_W'(gain);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Wait a random gap, then hold the sample until it transfers
    task automatic send_sample(input t_in item);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Drop valid and let every predicted sample come out, plus the pipeline
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int sent;
        int len;
        int n;
        bit pressed;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: long delay, so everything passes unchanged
        send_sample(mk_item(SAMPLE_MAX, 1'b1));
        send_sample(mk_item(SAMPLE_MIN, 1'b0));
        send_sample(mk_item(16'sd0, 1'b0));
        send_sample(mk_item(-16'sd1, 1'b0));
        drain();

        // One-sample delay, gain just under 2: clip both ways, exact low rail
        write_config(DELAY_W'(1), '1);
        send_sample(mk_item(SAMPLE_MAX, 1'b1));
        send_sample(mk_item(SAMPLE_MAX, 1'b0));
        send_sample(mk_item(SAMPLE_MIN, 1'b0));
        send_sample(mk_item(SAMPLE_MIN, 1'b1));
        send_sample(mk_item(SAMPLE_MIN, 1'b0));
        send_sample(mk_item(SAMPLE_MAX, 1'b0));
        send_sample(mk_item(16'sd0, 1'b0));
        drain();

        // Zero gain: the echo adds nothing
        write_config(DELAY_W'(2), '0);
        send_sample(mk_item(16'sd100, 1'b1));
        send_sample(mk_item(-16'sd5, 1'b0));
        send_sample(mk_item(16'sd7, 1'b0));
        send_sample(mk_item(-16'sd8, 1'b0));
        drain();

        // Zero delay: no echo at all
        write_config('0, GAIN_W'(32768));
        send_sample(mk_item(SAMPLE_MAX, 1'b1));
        send_sample(mk_item(16'sd1, 1'b0));
        send_sample(mk_item(SAMPLE_MIN, 1'b0));
        drain();

        // Half gain on odd negatives: truncate toward zero
        write_config(DELAY_W'(3), GAIN_W'(16384));
        send_sample(mk_item(-16'sd3, 1'b1));
        send_sample(mk_item(16'sd5, 1'b0));
        send_sample(mk_item(-16'sd7, 1'b0));
        send_sample(mk_item(16'sd1, 1'b0));
        send_sample(mk_item(16'sd2, 1'b0));
        send_sample(mk_item(-16'sd1, 1'b0));
        drain();

        // One-sample delay back to back: each echo is the sample just computed
        no_idle = 1'b1;
        write_config(DELAY_W'(1), GAIN_W'(40000));
        send_sample(mk_item(pick_sample(), 1'b1));
        repeat (199) send_sample(mk_item(pick_sample(), 1'b0));
        drain();
        no_idle = 1'b0;

        // Delays beyond the line clamp to its depth
        write_config('1, '1);
        repeat (60) send_sample(mk_item(pick_sample(), 1'b0));
        drain();
        write_config(DELAY_W'(ECHO_DEPTH + 1), GAIN_W'(1));
        repeat (30) send_sample(mk_item(pick_sample(), 1'b0));
        drain();

        // Random settings, each with a stream of random samples
        sent    = 0;
        pressed = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            write_config(pick_delay(), pick_gain());
            len = $urandom_range(60, 220);
            for (n = 0; n < len; n++) begin
                // Hold off the sender until every output is out
                if ((!pressed && n == 40) || $urandom_range(0, 199) == 0) begin
                    drain();
                    pressed = 1'b1;
                end
                if (n == 0) begin
                    send_sample(mk_item(pick_sample(), 1'($urandom_range(0, 1))));
                end else begin
                    send_sample(mk_item(pick_sample(), ($urandom_range(0, 63) == 0)));
                end
            end
            sent += len;
            drain();
        end

        if (errors == 0 && pending == 0) begin
            $display("** feedback_echo_saturating: PASSED **");
        end else begin
            $display("** feedback_echo_saturating: FAILED **");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/fes_pkg.sv
rtl/fes_scale_sat.sv
rtl/feedback_echo_saturating.sv
verif/echo_checker.sv
verif/testbench.sv
